FILE: rtl/lrle_pkg.sv
// Shared types and constants for the line run-length frame encoder.
// No dependencies; imported by every module of the block.
package lrle_pkg;

	// Fixed field widths
	localparam int PIXEL_BITS = 16;
	localparam int COORD_BITS = 12;
	localparam int LEN_BITS = 7;
	localparam int PKT_BITS = 8;
	localparam int BYTE_BITS = 26;
	localparam int ADD_BITS = 10;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	// Default packet limit and queue depth (power of two)
	localparam int MAX_PACKET_DEF = 127;
	localparam int QUEUE_DEPTH = 4;

	// Register indexes and reset values
	localparam logic [CFG_IDX_BITS-1:0] REG_COMPARE_MASK = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_COUNT = 2'd2;
	localparam logic [PIXEL_BITS-1:0] RST_COMPARE_MASK = 16'hFFFF;
	localparam logic [COORD_BITS-1:0] RST_LINE_WIDTH = 12'd320;
	localparam logic [COORD_BITS-1:0] RST_LINE_COUNT = 12'd200;

	// Encoded byte cost of a run packet and of a line header
	localparam logic [ADD_BITS-1:0] RUN_BYTES = 10'd3;
	localparam logic [ADD_BITS-1:0] LINE_BYTES = 10'd1;

	// Token kinds on the output
	typedef enum logic [1:0] {
		KIND_LIT_PIXEL = 2'd0,
		KIND_LIT_CLOSE = 2'd1,
		KIND_RUN = 2'd2,
		KIND_LINE_END = 2'd3
	} kind_t;

	// Open packet state
	typedef enum logic [2:0] {
		MODE_NONE = 3'b001,
		MODE_LIT = 3'b010,
		MODE_RUN = 3'b100
	} mode_t;

	// Token slots of one queue entry, in emission order
	localparam int SLOTS = 6;
	localparam int SLOT_LIT_A = 0;     // held pixel as literal
	localparam int SLOT_LIT_B = 1;     // incoming pixel as literal
	localparam int SLOT_LIT_CLOSE = 2;
	localparam int SLOT_RUN_A = 3;     // run of the held pixel
	localparam int SLOT_RUN_B = 4;     // single-pixel run of the incoming pixel
	localparam int SLOT_LINE_END = 5;

	// One classified pixel: which tokens it makes and their payloads
	typedef struct packed {
		logic [SLOTS-1:0] slots;
		logic [PIXEL_BITS-1:0] held;
		logic [PIXEL_BITS-1:0] pix;
		logic [LEN_BITS-1:0] lit_len;
		logic [LEN_BITS-1:0] run_len;
		logic [PKT_BITS-1:0] packets;
		logic [BYTE_BITS-1:0] bytes;
		logic done;
	} entry_t;

endpackage

FILE: rtl/lrle_front.sv
// Front end: configuration registers, packet scan state and classification
// of each accepted pixel into a queue entry. Depends on lrle_pkg.
module lrle_front import lrle_pkg::*; #(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data,
	input logic accept,
	input logic [PIXEL_BITS-1:0] pixel,
	output logic push,
	output entry_t entry
);

	localparam int LW = $clog2(MAX_PACKET + 1);
	localparam logic [LW-1:0] MAX_L = LW'(MAX_PACKET);
	localparam logic [LW-1:0] MAX_M1 = LW'(MAX_PACKET - 1);
	localparam logic [LW-1:0] TWO_L = LW'(2);

	logic [PIXEL_BITS-1:0] compare_mask_q;
	logic [COORD_BITS-1:0] line_width_q;
	logic [COORD_BITS-1:0] line_count_q;

	mode_t mode_q, mode_d;
	logic [PIXEL_BITS-1:0] held_q, held_d;
	logic [LW-1:0] len_q, len_d;
	logic [PKT_BITS-1:0] pk_q;
	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [BYTE_BITS-1:0] bytes_q;

	logic [COORD_BITS:0] col_inc;
	logic [COORD_BITS:0] row_inc;
	logic eol;
	logic done;
	logic same;
	logic [LW-1:0] nl;
	logic [LW-1:0] nl2;
	logic [ADD_BITS-1:0] add;
	logic [1:0] pk_inc;
	logic [PKT_BITS-1:0] pk_new;
	logic [BYTE_BITS:0] byte_sum;
	logic [BYTE_BITS-1:0] bytes_new;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_mask_q <= RST_COMPARE_MASK;
			line_width_q <= RST_LINE_WIDTH;
			line_count_q <= RST_LINE_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COMPARE_MASK: compare_mask_q <= cfg_data[PIXEL_BITS-1:0];
				REG_LINE_WIDTH: line_width_q <= cfg_data[COORD_BITS-1:0];
				REG_LINE_COUNT: line_count_q <= cfg_data[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Position and equality tests
	assign col_inc = {1'b0, col_q} + 1'b1;
	assign row_inc = {1'b0, row_q} + 1'b1;
	assign eol = col_inc >= {1'b0, line_width_q};
	assign done = row_inc >= {1'b0, line_count_q};
	assign same = ((pixel ^ held_q) & compare_mask_q) == '0;
	assign nl = len_q + 1'b1;
	assign nl2 = nl + 1'b1;

	// Packet decisions for the incoming pixel
	always_comb begin
		mode_d = mode_q;
		held_d = held_q;
		len_d = len_q;
		add = '0;
		pk_inc = '0;
		entry = '0;
		entry.held = held_q;
		entry.pix = pixel;
		case (mode_q)
			MODE_LIT: begin
				if (same) begin
					// pending literal closes, the pair opens a run
					if (len_q != '0) begin
						entry.slots[SLOT_LIT_CLOSE] = 1'b1;
						entry.lit_len = LEN_BITS'(len_q);
						pk_inc = pk_inc + 1'b1;
						add = add + ADD_BITS'({len_q, 1'b1});
					end
					if (MAX_L <= TWO_L || eol) begin
						entry.slots[SLOT_RUN_A] = 1'b1;
						entry.run_len = LEN_BITS'(TWO_L);
						pk_inc = pk_inc + 1'b1;
						add = add + RUN_BYTES;
						mode_d = MODE_NONE;
						len_d = '0;
					end else begin
						mode_d = MODE_RUN;
						len_d = TWO_L;
					end
				end else begin
					// held pixel is confirmed as literal
					entry.slots[SLOT_LIT_A] = 1'b1;
					if (nl >= MAX_M1 || eol) begin
						entry.slots[SLOT_LIT_B] = 1'b1;
						entry.slots[SLOT_LIT_CLOSE] = 1'b1;
						entry.lit_len = LEN_BITS'(nl2);
						pk_inc = pk_inc + 1'b1;
						add = add + ADD_BITS'({nl2, 1'b1});
						mode_d = MODE_NONE;
						len_d = '0;
					end else begin
						held_d = pixel;
						len_d = nl;
					end
				end
			end
			MODE_RUN: begin
				if (same) begin
					if (nl >= MAX_L || eol) begin
						entry.slots[SLOT_RUN_A] = 1'b1;
						entry.run_len = LEN_BITS'(nl);
						pk_inc = pk_inc + 1'b1;
						add = add + RUN_BYTES;
						mode_d = MODE_NONE;
						len_d = '0;
					end else begin
						len_d = nl;
					end
				end else begin
					// run closes, new pixel opens a packet
					entry.slots[SLOT_RUN_A] = 1'b1;
					entry.run_len = LEN_BITS'(len_q);
					pk_inc = pk_inc + 1'b1;
					add = add + RUN_BYTES;
					held_d = pixel;
					len_d = '0;
					if (eol) begin
						entry.slots[SLOT_RUN_B] = 1'b1;
						pk_inc = pk_inc + 1'b1;
						add = add + RUN_BYTES;
						mode_d = MODE_NONE;
					end else begin
						mode_d = MODE_LIT;
					end
				end
			end
			default: begin
				// no open packet
				held_d = pixel;
				len_d = '0;
				if (eol) begin
					entry.slots[SLOT_RUN_B] = 1'b1;
					pk_inc = pk_inc + 1'b1;
					add = add + RUN_BYTES;
					mode_d = MODE_NONE;
				end else begin
					mode_d = MODE_LIT;
				end
			end
		endcase

		// line totals
		pk_new = pk_q + PKT_BITS'(pk_inc);
		byte_sum = {1'b0, bytes_q} + (BYTE_BITS+1)'(add) + (BYTE_BITS+1)'(eol ? LINE_BYTES : '0);
		bytes_new = byte_sum[BYTE_BITS] ? '1 : byte_sum[BYTE_BITS-1:0];
		if (eol) begin
			entry.slots[SLOT_LINE_END] = 1'b1;
			entry.packets = pk_new;
			entry.bytes = bytes_new;
			entry.done = done;
		end
	end

	assign push = accept && (entry.slots != '0);

	// Scan state update on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
			held_q <= '0;
			len_q <= '0;
			pk_q <= '0;
			col_q <= '0;
			row_q <= '0;
			bytes_q <= '0;
		end else if (accept) begin
			held_q <= held_d;
			if (eol) begin
				mode_q <= MODE_NONE;
				len_q <= '0;
				pk_q <= '0;
				col_q <= '0;
				row_q <= done ? '0 : row_inc[COORD_BITS-1:0];
				bytes_q <= done ? '0 : bytes_new;
			end else begin
				mode_q <= mode_d;
				len_q <= len_d;
				pk_q <= pk_new;
				col_q <= col_inc[COORD_BITS-1:0];
				bytes_q <= bytes_new;
			end
		end
	end

endmodule

FILE: rtl/lrle_queue.sv
// Short queue of classified entries between front and back end.
// Depends on lrle_pkg.
module lrle_queue import lrle_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input entry_t push_data,
	input logic pop,
	output logic full,
	output logic head_valid,
	output entry_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	entry_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = count_q == DEPTH_C;
	assign head_valid = count_q != '0;
	assign head = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/lrle_back.sv
// Back end: expands one queue entry into its tokens, one per cycle unless stalled,
// into the output register. Depends on lrle_pkg.
module lrle_back import lrle_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input entry_t head,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] kind,
	output logic [PIXEL_BITS-1:0] value,
	output logic [LEN_BITS-1:0] run_length,
	output logic [PKT_BITS-1:0] packets_in_line,
	output logic [BYTE_BITS-1:0] byte_total,
	output logic frame_done,
	output logic last
);

	entry_t cur_q;
	logic [SLOTS-1:0] rem_q;
	logic [SLOTS-1:0] sel;
	logic [SLOTS-1:0] rem_after;
	logic out_load;
	logic emit;

	logic out_valid_q;
	kind_t kind_q, kind_d;
	logic [PIXEL_BITS-1:0] value_q, value_d;
	logic [LEN_BITS-1:0] len_q, len_d;
	logic [PKT_BITS-1:0] pk_q, pk_d;
	logic [BYTE_BITS-1:0] bytes_q, bytes_d;
	logic done_q, done_d;
	logic last_q;

	// Lowest pending slot goes out next
	assign sel = rem_q & (~rem_q + 1'b1);
	assign rem_after = rem_q & ~sel;
	assign out_load = !out_valid_q || !out_stall;
	assign emit = out_load && (rem_q != '0);
	assign pop = head_valid && ((rem_q == '0) || (emit && (rem_after == '0)));

	// Token payload for the selected slot
	always_comb begin
		kind_d = KIND_LIT_PIXEL;
		value_d = '0;
		len_d = '0;
		pk_d = '0;
		bytes_d = '0;
		done_d = 1'b0;
		if (sel[SLOT_LIT_A]) begin
			value_d = cur_q.held;
		end else if (sel[SLOT_LIT_B]) begin
			value_d = cur_q.pix;
		end else if (sel[SLOT_LIT_CLOSE]) begin
			kind_d = KIND_LIT_CLOSE;
			len_d = cur_q.lit_len;
		end else if (sel[SLOT_RUN_A]) begin
			kind_d = KIND_RUN;
			value_d = cur_q.held;
			len_d = cur_q.run_len;
		end else if (sel[SLOT_RUN_B]) begin
			kind_d = KIND_RUN;
			value_d = cur_q.pix;
			len_d = LEN_BITS'(1);
		end else if (sel[SLOT_LINE_END]) begin
			kind_d = KIND_LINE_END;
			pk_d = cur_q.packets;
			bytes_d = cur_q.bytes;
			done_d = cur_q.done;
		end
	end

	// Current entry and its remaining slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (pop) begin
			rem_q <= head.slots;
		end else if (emit) begin
			rem_q <= rem_after;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= kind_d;
			value_q <= value_d;
			len_q <= len_d;
			pk_q <= pk_d;
			bytes_q <= bytes_d;
			done_q <= done_d;
			last_q <= rem_after == '0;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign value = value_q;
	assign run_length = len_q;
	assign packets_in_line = pk_q;
	assign byte_total = bytes_q;
	assign frame_done = done_q;
	assign last = last_q;

endmodule

FILE: rtl/line_run_length_frame_encoder.sv
// Channel   | Signals                                  | Transfer when
// ----------+------------------------------------------+---------------------------
// in        | in_valid, in_stall, pixel                | in_valid && !in_stall
// out       | out_valid, out_stall, kind .. last       | out_valid && !out_stall
// cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid && cfg_ready
//
// The front end takes one pixel per cycle while the entry queue has room.
// The back end sends one token per cycle unless stalled; a pixel making n tokens
// holds it until all n are sent, so output token rate bounds sustained throughput.
// Tokens pass the queue slot, the back end's entry and the output register.
// arst_n clears scan state, queue and output valid; no clearing pass.
// Top level: line run-length frame encoder. Depends on lrle_pkg,
// lrle_front, lrle_queue and lrle_back.
module line_run_length_frame_encoder import lrle_pkg::*; #(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [PIXEL_BITS-1:0] pixel,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] kind,
	output logic [PIXEL_BITS-1:0] value,
	output logic [LEN_BITS-1:0] run_length,
	output logic [PKT_BITS-1:0] packets_in_line,
	output logic [BYTE_BITS-1:0] byte_total,
	output logic frame_done,
	output logic last
);

	logic accept;
	logic push;
	entry_t entry;
	logic full;
	logic head_valid;
	entry_t head;
	logic pop;

	assign cfg_ready = 1'b1;
	assign in_stall = full;
	assign accept = in_valid && !full;

	lrle_front #(
		.MAX_PACKET(MAX_PACKET)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.pixel(pixel),
		.push(push),
		.entry(entry)
	);

	lrle_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(entry),
		.pop(pop),
		.full(full),
		.head_valid(head_valid),
		.head(head)
	);

	lrle_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.value(value),
		.run_length(run_length),
		.packets_in_line(packets_in_line),
		.byte_total(byte_total),
		.frame_done(frame_done),
		.last(last)
	);

endmodule

FILE: rtl/lrle_checker.sv
// Port-level checks for the line run-length frame encoder, bound to the
// top level. Depends on lrle_pkg.
module lrle_checker import lrle_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data,
	input logic in_valid,
	input logic in_stall,
	input logic [PIXEL_BITS-1:0] pixel,
	input logic out_valid,
	input logic out_stall,
	input logic [1:0] kind,
	input logic [PIXEL_BITS-1:0] value,
	input logic [LEN_BITS-1:0] run_length,
	input logic [PKT_BITS-1:0] packets_in_line,
	input logic [BYTE_BITS-1:0] byte_total,
	input logic frame_done,
	input logic last
);

	// A stalled token holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value)
			&& $stable(run_length) && $stable(last))
		else $error("stalled output token changed");

	// Line fields only on line end tokens
	a_line_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_LINE_END) |->
			packets_in_line == '0 && byte_total == '0 && !frame_done)
		else $error("line fields set on non line end token");

	// Literal close carries a count and no pixel
	a_close_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_LIT_CLOSE) |-> run_length != '0 && value == '0)
		else $error("bad literal close token");

	// Runs always cover at least one pixel
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_RUN) |-> run_length != '0)
		else $error("run token with zero length");

	// Line end is always the final token of its pixel
	a_line_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_LINE_END) |-> last)
		else $error("line end token not marked last");

endmodule

bind line_run_length_frame_encoder lrle_checker u_lrle_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for line_run_length_frame_encoder: a directed table,
// then random frames, checked per token against an in-bench encoder or typed rows.
// Depends on lrle_pkg and the encoder RTL only.
module tb_top;
	import lrle_pkg::*;

	// Timing and run limits
	localparam int DRAIN_PAUSE = 16;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [BYTE_BITS-1:0] BYTES_MAX = 26'h3FFFFFF;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam logic ROW_PIX = 1'b0;
	localparam logic ROW_CFG = 1'b1;

	// One output token as the encoder should send it
	typedef struct packed {
		kind_t kind;
		logic [PIXEL_BITS-1:0] value;
		logic [LEN_BITS-1:0] len;
		logic [PKT_BITS-1:0] packets;
		logic [BYTE_BITS-1:0] bytes;
		logic done;
		logic last;
	} token_t;

	// Directed stimulus row: a register write or a pixel, with optional typed tokens
	typedef struct packed {
		logic is_cfg;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [CFG_DATA_BITS-1:0] data;
		logic [1:0] n_typed;
		token_t t0;
		token_t t1;
	} row_t;

	typedef enum logic [1:0] {
		OPEN_NONE = 2'd0,
		OPEN_LIT = 2'd1,
		OPEN_RUN = 2'd2
	} open_t;

	localparam token_t NO_TOK = '0;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [PIXEL_BITS-1:0] pixel;
	logic out_valid;
	logic out_stall;
	logic [1:0] kind;
	logic [PIXEL_BITS-1:0] value;
	logic [LEN_BITS-1:0] run_length;
	logic [PKT_BITS-1:0] packets_in_line;
	logic [BYTE_BITS-1:0] byte_total;
	logic frame_done;
	logic last;

	line_run_length_frame_encoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.value(value),
		.run_length(run_length),
		.packets_in_line(packets_in_line),
		.byte_total(byte_total),
		.frame_done(frame_done),
		.last(last)
	);

	// Encoder registers and scan state as seen by the bench
	logic [PIXEL_BITS-1:0] reg_mask = RST_COMPARE_MASK;
	logic [COORD_BITS-1:0] reg_width = RST_LINE_WIDTH;
	logic [COORD_BITS-1:0] reg_count = RST_LINE_COUNT;
	open_t open_mode = OPEN_NONE;
	logic [PIXEL_BITS-1:0] held_pix = '0;
	int pkt_len = 0;
	logic [PKT_BITS-1:0] line_pk = '0;
	logic [COORD_BITS-1:0] scan_col = '0;
	logic [COORD_BITS-1:0] scan_row = '0;
	logic [BYTE_BITS-1:0] enc_bytes = '0;

	token_t tokens_due[$];
	row_t dir_rows[$];
	int step_count;
	int errors = 0;
	int pixels_sent = 0;
	int tokens_seen = 0;
	int cfg_writes = 0;
	int cycles = 0;
	int stall_cnt = 0;
	bit calm = 0;
	logic [PIXEL_BITS-1:0] prev_pix = '0;
	int burst_left = 0;

	// Clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Idle length: mostly short, now and then long
	function automatic int gap_len();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// ---- encoder prediction ----

	function automatic void emit_tok(kind_t k, logic [PIXEL_BITS-1:0] v, int n, int pk,
			logic [BYTE_BITS-1:0] b, logic d);
		token_t t;
		t.kind = k;
		t.value = v;
		t.len = n[LEN_BITS-1:0];
		t.packets = pk[PKT_BITS-1:0];
		t.bytes = b;
		t.done = d;
		t.last = 1'b0;
		tokens_due.push_back(t);
		step_count++;
	endfunction

	// Saturating byte counter
	function automatic void add_bytes(int n);
		logic [BYTE_BITS-1:0] room;
		room = BYTES_MAX - enc_bytes;
		if (n >= int'(room))
			enc_bytes = BYTES_MAX;
		else
			enc_bytes = enc_bytes + BYTE_BITS'(n);
	endfunction

	function automatic bit masked_equal(logic [PIXEL_BITS-1:0] a, logic [PIXEL_BITS-1:0] b);
		return ((a ^ b) & reg_mask) == '0;
	endfunction

	function automatic void close_literal(int n);
		emit_tok(KIND_LIT_CLOSE, '0, n, 0, '0, 1'b0);
		line_pk = line_pk + 1'b1;
		add_bytes(1 + 2 * n);
		open_mode = OPEN_NONE;
		pkt_len = 0;
	endfunction

	function automatic void close_run();
		emit_tok(KIND_RUN, held_pix, pkt_len, 0, '0, 1'b0);
		line_pk = line_pk + 1'b1;
		add_bytes(int'(RUN_BYTES));
		open_mode = OPEN_NONE;
		pkt_len = 0;
	endfunction

	function automatic void start_packet(logic [PIXEL_BITS-1:0] x, bit eol);
		held_pix = x;
		if (eol) begin
			pkt_len = 1;
			close_run();
		end else begin
			open_mode = OPEN_LIT;
			pkt_len = 0;
		end
	endfunction

	// Advance the scan by one accepted pixel and queue the tokens it makes
	function automatic void encode_pixel(logic [PIXEL_BITS-1:0] x);
		bit eol;
		bit done;
		token_t t;
		step_count = 0;
		eol = (int'(scan_col) + 1) >= int'(reg_width);
		case (open_mode)
			OPEN_LIT: begin
				if (masked_equal(x, held_pix)) begin
					if (pkt_len > 0)
						close_literal(pkt_len);
					open_mode = OPEN_RUN;
					pkt_len = 2;
					if (pkt_len >= MAX_PACKET_DEF || eol)
						close_run();
				end else begin
					emit_tok(KIND_LIT_PIXEL, held_pix, 0, 0, '0, 1'b0);
					pkt_len++;
					if (pkt_len >= MAX_PACKET_DEF - 1 || eol) begin
						emit_tok(KIND_LIT_PIXEL, x, 0, 0, '0, 1'b0);
						close_literal(pkt_len + 1);
					end else begin
						held_pix = x;
					end
				end
			end
			OPEN_RUN: begin
				if (masked_equal(x, held_pix)) begin
					pkt_len++;
					if (pkt_len >= MAX_PACKET_DEF || eol)
						close_run();
				end else begin
					close_run();
					start_packet(x, eol);
				end
			end
			default: start_packet(x, eol);
		endcase

		// Line end token, frame wrap
		if (eol) begin
			done = (int'(scan_row) + 1) >= int'(reg_count);
			add_bytes(int'(LINE_BYTES));
			emit_tok(KIND_LINE_END, '0, 0, int'(line_pk), enc_bytes, done);
			open_mode = OPEN_NONE;
			pkt_len = 0;
			line_pk = '0;
			scan_col = '0;
			if (done) begin
				scan_row = '0;
				enc_bytes = '0;
			end else begin
				scan_row = scan_row + 1'b1;
			end
		end else begin
			scan_col = scan_col + 1'b1;
		end

		if (step_count > 0) begin
			t = tokens_due.pop_back();
			t.last = 1'b1;
			tokens_due.push_back(t);
		end
	endfunction

	// ---- drivers ----

	// Drop the input, let every queued token out, then give the block time to settle
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_COMPARE_MASK: reg_mask = data;
			REG_LINE_WIDTH: reg_width = data[COORD_BITS-1:0];
			REG_LINE_COUNT: reg_count = data[COORD_BITS-1:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One pixel transfer, with an optional idle gap ahead of it
	task automatic send_pixel(input logic [PIXEL_BITS-1:0] x);
		int gap;
		gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel <= x;
		do @(posedge clk); while (in_stall);
		encode_pixel(x);
		pixels_sent++;
	endtask

	// Random pixel stream: runs, mask-equal variants, ramps and noise
	function automatic logic [PIXEL_BITS-1:0] next_pixel();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return prev_pix;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			burst_left = $urandom_range(20, 140);
		else if (r < 38)
			;
		else if (r < 53)
			prev_pix = prev_pix ^ (PIXEL_BITS'($urandom) & ~reg_mask);
		else if (r < 68)
			prev_pix = prev_pix + 1'b1;
		else
			prev_pix = PIXEL_BITS'($urandom);
		return prev_pix;
	endfunction

	// Output stall generator
	always @(negedge clk) begin
		if (stall_cnt != 0) begin
			out_stall <= 1'b1;
			stall_cnt--;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_cnt = gap_len() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---- checking ----

	function automatic void check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		token_t want;
		if (arst_n && out_valid && !out_stall) begin
			tokens_seen++;
			if (tokens_due.size() == 0) begin
				$display("%0t: token with nothing expected, got kind %0d value %h len %0d",
					$time, kind, value, run_length);
				errors++;
			end else begin
				want = tokens_due.pop_front();
				check_field("kind", want.kind, kind);
				check_field("value", want.value, value);
				check_field("run_length", want.len, run_length);
				check_field("packets_in_line", want.packets, packets_in_line);
				check_field("byte_total", want.bytes, byte_total);
				check_field("frame_done", want.done, frame_done);
				check_field("last", want.last, last);
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("cycle limit hit, %0d tokens still outstanding", tokens_due.size());
			$display("tb_top failed");
			$finish;
		end
	end

	// ---- stimulus ----

	initial begin
		int n;
		int typed;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] c;
		logic [PIXEL_BITS-1:0] m;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel = '0;
		out_stall = 1'b0;

		// Directed table; pixel rows leave idx unused
		// 1-pixel lines, two lines per frame
		dir_rows.push_back(row_t'{ROW_CFG, REG_LINE_COUNT, 16'd2, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_CFG, REG_LINE_WIDTH, 16'd1, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'hFFFF, 2'd2,
			'{KIND_RUN, 16'hFFFF, 7'd1, 8'd0, 26'd0, 1'b0, 1'b0},
			'{KIND_LINE_END, 16'h0, 7'd0, 8'd1, 26'd4, 1'b0, 1'b1}});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h0000, 2'd2,
			'{KIND_RUN, 16'h0000, 7'd1, 8'd0, 26'd0, 1'b0, 1'b0},
			'{KIND_LINE_END, 16'h0, 7'd0, 8'd1, 26'd8, 1'b1, 1'b1}});
		// zero width and zero count: each pixel is a line and a frame
		dir_rows.push_back(row_t'{ROW_CFG, REG_LINE_WIDTH, 16'h1000, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_CFG, REG_LINE_COUNT, 16'hF000, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h8001, 2'd2,
			'{KIND_RUN, 16'h8001, 7'd1, 8'd0, 26'd0, 1'b0, 1'b0},
			'{KIND_LINE_END, 16'h0, 7'd0, 8'd1, 26'd4, 1'b1, 1'b1}});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h7FFE, 2'd2,
			'{KIND_RUN, 16'h7FFE, 7'd1, 8'd0, 26'd0, 1'b0, 1'b0},
			'{KIND_LINE_END, 16'h0, 7'd0, 8'd1, 26'd4, 1'b1, 1'b1}});
		// widest lines, low-byte compare
		dir_rows.push_back(row_t'{ROW_CFG, REG_LINE_WIDTH, 16'h0FFF, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_CFG, REG_LINE_COUNT, 16'h0FFF, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_CFG, REG_COMPARE_MASK, 16'h00FF, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h1234, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'hAB34, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h0034, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h0035, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h0036, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'hFF36, 2'd0, NO_TOK, NO_TOK});
		// shrink the width below the current column
		dir_rows.push_back(row_t'{ROW_CFG, REG_LINE_WIDTH, 16'd3, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h0037, 2'd0, NO_TOK, NO_TOK});
		// empty mask: everything matches
		dir_rows.push_back(row_t'{ROW_CFG, REG_COMPARE_MASK, 16'h0000, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h5555, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'hAAAA, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h0F0F, 2'd0, NO_TOK, NO_TOK});
		// full mask, literal running into the line end
		dir_rows.push_back(row_t'{ROW_CFG, REG_COMPARE_MASK, 16'hFFFF, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_CFG, REG_LINE_WIDTH, 16'd4, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h0001, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h0002, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h0003, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h0004, 2'd0, NO_TOK, NO_TOK});
		// write to the unused index must not disturb anything
		dir_rows.push_back(row_t'{ROW_CFG, REG_UNUSED, 16'h0002, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h0005, 2'd0, NO_TOK, NO_TOK});
		dir_rows.push_back(row_t'{ROW_PIX, REG_COMPARE_MASK, 16'h0005, 2'd0, NO_TOK, NO_TOK});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_pixel(dir_rows[i].data);
				typed = dir_rows[i].n_typed;
				if (typed != 0) begin
					// hand-computed tokens stand in for the predicted ones
					repeat (step_count) void'(tokens_due.pop_back());
					tokens_due.push_back(dir_rows[i].t0);
					if (typed > 1)
						tokens_due.push_back(dir_rows[i].t1);
				end
			end
		end

		// Longest run, then longest literal, in one line
		write_reg(REG_LINE_WIDTH, 16'd260);
		write_reg(REG_LINE_COUNT, 16'd2);
		repeat (130) send_pixel(16'h4242);
		for (int i = 0; i < 130; i++)
			send_pixel(16'h1000 + 16'(i));

		// Random settings and streams
		for (int ph = 0; ph < 8; ph++) begin
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: w = '0;
				1: w = 12'hFFF;
				2: w = 12'($urandom_range(100, 300));
				default: w = 12'($urandom_range(1, 24));
			endcase
			c = ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom_range(0, 5));
			case ($urandom_range(0, 4))
				0: m = 16'hFFFF;
				1: m = 16'h0000;
				3: m = 16'hFF00;
				default: m = PIXEL_BITS'($urandom);
			endcase
			write_reg(REG_LINE_WIDTH, {4'($urandom), w});
			write_reg(REG_LINE_COUNT, {4'($urandom), c});
			write_reg(REG_COMPARE_MASK, m);
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
			n = $urandom_range(18, 28);
			repeat (n) send_pixel(next_pixel());
		end

		// Drain and finish
		calm = 0;
		settle();
		$display("Summary: %0d pixels sent, %0d tokens checked, %0d register writes",
			pixels_sent, tokens_seen, cfg_writes);
		$display("Covered zero, small and full widths and counts, masks, longest packets");
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

FILE: line_run_length_frame_encoder.f
rtl/lrle_pkg.sv
rtl/lrle_front.sv
rtl/lrle_queue.sv
rtl/lrle_back.sv
rtl/line_run_length_frame_encoder.sv
rtl/lrle_checker.sv
tb/tb_top.sv
